[rtl/core/tksel_pkg.sv]
// Shared types and constants of the top-K score selector.
package tksel_pkg;

    localparam int MAX_KEEP_DEF   = 16;
    localparam int INDEX_BITS_DEF = 8;

    localparam int SCORE_W = 16;
    localparam logic signed [SCORE_W-1:0] SCORE_EMPTY = -16'sd256;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_CAND   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_KEEP   = 2'd1;
    localparam logic [1:0] CFG_DELAY  = 2'd2;

    localparam logic [4:0]  KEEP_RESET  = 5'd1;
    localparam logic [15:0] DELAY_RESET = 16'd1000;

    typedef struct packed {
        logic clear;
        logic insert;
        logic first;
    } cell_ctrl_t;

endpackage

[rtl/core/top_k_score_selector_core.sv]
// Top level of the top-K score selector: control, timer, slot chain and output.
//
// Input stream s_*: one request per item, s_tuser carries the op code
// (begin round, candidate, end round, finish). Output stream m_*: one result
// per request, in order. Configuration writes (enable, keep count, think
// delay) arrive on cfg_*, always ready; the user must make them only while
// the block is idle, which the block itself does not enforce. Begin, candidate
// and finish requests write their result to the output buffer at the accepting
// edge, and candidates insert into the compare cell chain at that edge, so
// they stream one per cycle while s_tready is high. An open round's end request
// scales rand_pick by the kept count with one small multiplier when taken;
// the pick state then reads the chosen slot through the slot mux with s_tready
// low. The output buffer holds two results, so requests keep being taken while
// one waits; when both wait on a stalled receiver s_tready drops.
// Reset: timer zero, no round open, all slot scores -1.0, no behavior held,
// registers at enable 1, keep count 1, think delay 1000.
module top_k_score_selector_core
    import tksel_pkg::*;
#(
    parameter int MAX_KEEP   = MAX_KEEP_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int IN_W  = ((49 + INDEX_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((5 + 3 * INDEX_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // fields from bit 0: elapsed, can_interrupt, cand_index, cand_score, rand_pick
    input  logic [IN_W-1:0]  s_tdata,
    // fields from bit 0: op
    input  logic [1:0]       s_tuser,
    input  logic             s_tvalid,
    output logic             s_tready,
    // fields from bit 0: accepted, none_found, top_index, chosen_index,
    // changed, previous_ended, now_valid, now_index
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int PW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int IB = INDEX_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PICK = 1'b1;

    logic                  enable_reg;
    logic [4:0]            keep_reg;
    logic [15:0]           delay_reg;
    logic signed [17:0]    timer_reg;
    logic                  round_reg;
    logic [CW-1:0]         count_reg;
    logic [IB-1:0]         active_index_reg;
    logic                  active_valid_reg;
    logic                  state_reg;
    logic [PW-1:0]         pick_reg;
    logic [CW-1:0]         n_reg;

    logic [1:0]            op;
    logic [15:0]           elapsed;
    logic                  can_int;
    logic [IB-1:0]         cand_index;
    logic signed [15:0]    cand_score;
    logic [15:0]           rand_pick;

    logic                  accept;
    logic                  full;
    logic                  push;
    logic [OUT_W-1:0]      res;
    logic [CW-1:0]         keep_eff;
    logic [CW-1:0]         n_now;
    logic [16+CW-1:0]      product;
    logic signed [17:0]    timer_diff;
    logic                  timer_done;
    logic                  open_round;
    cell_ctrl_t            ctrl;

    logic [MAX_KEEP:0]                found;
    logic [IB-1:0]                    slot_idx [MAX_KEEP];
    logic signed [SCORE_W-1:0]        slot_scr [MAX_KEEP];

    logic                  r_acc;
    logic                  r_none;
    logic [IB-1:0]         r_top;
    logic [IB-1:0]         r_chosen;
    logic                  r_chg;
    logic                  r_ended;
    logic                  av_next;
    logic [IB-1:0]         ai_next;

    assign op         = s_tuser;
    assign elapsed    = s_tdata[15:0];
    assign can_int    = s_tdata[16];
    assign cand_index = s_tdata[17 +: IB];
    assign cand_score = s_tdata[17 + IB +: 16];
    assign rand_pick  = s_tdata[33 + IB +: 16];

    assign s_tready  = (state_reg == ST_IDLE) && !full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            keep_reg   <= KEEP_RESET;
            delay_reg  <= DELAY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_KEEP:   keep_reg   <= cfg_data[4:0];
                CFG_DELAY:  delay_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (keep_reg == 5'd0) begin
            keep_eff = CW'(1);
        end else if (int'(keep_reg) > MAX_KEEP) begin
            keep_eff = CW'(MAX_KEEP);
        end else begin
            keep_eff = CW'(keep_reg);
        end
    end

    assign n_now      = (count_reg < keep_eff) ? count_reg : keep_eff;
    assign product    = rand_pick * n_now;
    assign timer_diff = timer_reg - $signed({2'b00, elapsed});
    assign timer_done = timer_diff[17] || (timer_diff == 18'sd0);
    assign open_round = enable_reg && timer_done && (!active_valid_reg || can_int);

    assign ctrl.clear  = accept && op == OP_BEGIN && open_round;
    assign ctrl.insert = accept && op == OP_CAND && round_reg;
    assign ctrl.first  = count_reg == '0;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
        logic [IB-1:0]             left_idx;
        logic signed [SCORE_W-1:0] left_scr;
        if (i == 0) begin : g_head
            assign left_idx = cand_index;
            assign left_scr = cand_score;
        end else begin : g_body
            assign left_idx = slot_idx[i-1];
            assign left_scr = slot_scr[i-1];
        end
        tksel_cell #(
            .INDEX_BITS(INDEX_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .in_range   (keep_eff > CW'(i)),
            .cand_index (cand_index),
            .cand_score (cand_score),
            .found_in   (found[i]),
            .left_index (left_idx),
            .left_score (left_scr),
            .found_out  (found[i+1]),
            .slot_index (slot_idx[i]),
            .slot_score (slot_scr[i])
        );
    end

    always_comb begin
        r_acc    = 1'b0;
        r_none   = 1'b0;
        r_top    = '0;
        r_chosen = '0;
        r_chg    = 1'b0;
        r_ended  = 1'b0;
        av_next  = active_valid_reg;
        ai_next  = active_index_reg;
        if (state_reg == ST_PICK) begin
            r_acc = 1'b1;
            if (n_reg == '0) begin
                r_none = 1'b1;
                if (active_valid_reg) begin
                    r_ended = 1'b1;
                    av_next = 1'b0;
                    ai_next = '0;
                end
            end else begin
                r_top    = slot_idx[0];
                r_chosen = slot_idx[pick_reg];
                if (!(active_valid_reg && active_index_reg == r_chosen)) begin
                    r_ended = active_valid_reg;
                    av_next = 1'b1;
                    ai_next = r_chosen;
                    r_chg   = 1'b1;
                end
            end
        end else begin
            case (op)
                OP_BEGIN:  r_acc = open_round;
                OP_CAND:   r_acc = round_reg;
                OP_END:    r_acc = 1'b0;
                OP_FINISH: begin
                    if (active_valid_reg) begin
                        r_acc   = 1'b1;
                        r_ended = 1'b1;
                        av_next = 1'b0;
                        ai_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res               = '0;
        res[0]            = r_acc;
        res[1]            = r_none;
        res[2 +: IB]      = r_top;
        res[2 + IB +: IB] = r_chosen;
        res[2 + 2*IB]     = r_chg;
        res[3 + 2*IB]     = r_ended;
        res[4 + 2*IB]     = av_next;
        res[5 + 2*IB +: IB] = av_next ? ai_next : '0;
    end

    assign push = (state_reg == ST_PICK) ||
                  (accept && !(op == OP_END && round_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            timer_reg        <= '0;
            round_reg        <= 1'b0;
            count_reg        <= '0;
            active_valid_reg <= 1'b0;
            active_index_reg <= '0;
        end else begin
            if (push) begin
                active_valid_reg <= av_next;
                active_index_reg <= ai_next;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (op)
                            OP_BEGIN: begin
                                if (enable_reg) begin
                                    timer_reg <= timer_done ?
                                                 $signed({2'b00, delay_reg}) : timer_diff;
                                end
                                if (open_round) begin
                                    round_reg <= 1'b1;
                                    count_reg <= '0;
                                end
                            end
                            OP_CAND: begin
                                if (round_reg) begin
                                    if (ctrl.first) begin
                                        count_reg <= CW'(1);
                                    end else if (found[MAX_KEEP] && count_reg < keep_eff) begin
                                        count_reg <= count_reg + CW'(1);
                                    end
                                end
                            end
                            OP_END: begin
                                if (round_reg) begin
                                    round_reg <= 1'b0;
                                    state_reg <= ST_PICK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PICK: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && op == OP_END) begin
            pick_reg <= product[16 +: PW];
            n_reg    <= n_now;
        end
    end

    tksel_obuf #(
        .W(OUT_W)
    ) u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .din      (res),
        .full     (full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_KEEP)
        else $error("kept count above chain length");

    a_pick_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PICK |-> !s_tready)
        else $error("request taken during pick");

    a_end_to_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_END && round_reg) |=> (state_reg == ST_PICK && !round_reg))
        else $error("end of open round did not enter pick");

    a_pick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK && n_reg != '0) |-> (CW'(pick_reg) < n_reg))
        else $error("picked slot outside kept entries");
`endif

endmodule

[rtl/core/tksel_cell.sv]
// One slot of the sorted score chain: compare, insert or shift down.
module tksel_cell
    import tksel_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cell_ctrl_t                    ctrl,
    input  logic                          in_range,
    input  logic [INDEX_BITS-1:0]         cand_index,
    input  logic signed [SCORE_W-1:0]     cand_score,
    input  logic                          found_in,
    input  logic [INDEX_BITS-1:0]         left_index,
    input  logic signed [SCORE_W-1:0]     left_score,
    output logic                          found_out,
    output logic [INDEX_BITS-1:0]         slot_index,
    output logic signed [SCORE_W-1:0]     slot_score
);

    logic [INDEX_BITS-1:0]     index_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic                      gt;
    logic                      take;
    logic                      shift;

    assign gt        = cand_score > score_reg;
    assign found_out = found_in | (in_range & (gt | ctrl.first));
    assign take      = ctrl.insert & in_range & !found_in & (gt | ctrl.first);
    assign shift     = ctrl.insert & in_range & found_in & !ctrl.first;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg <= SCORE_EMPTY;
        end else if (ctrl.clear) begin
            score_reg <= SCORE_EMPTY;
        end else if (shift) begin
            score_reg <= left_score;
        end else if (take) begin
            score_reg <= cand_score;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            index_reg <= left_index;
        end else if (take) begin
            index_reg <= cand_index;
        end
    end

    assign slot_index = index_reg;
    assign slot_score = score_reg;

endmodule

[rtl/core/tksel_obuf.sv]
// Two-entry result buffer between the selector and the output channel.
module tksel_obuf
    import tksel_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [W-1:0] m_tdata
);

    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic [W-1:0] ent0_reg;
    logic [W-1:0] ent1_reg;
    logic         pop;

    assign pop = m_tvalid & m_tready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (push && count_reg == 2'd1) begin
                ent0_reg <= din;
            end else begin
                ent0_reg <= ent1_reg;
            end
            if (push && count_reg == 2'd2) begin
                ent1_reg <= din;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                ent0_reg <= din;
            end else begin
                ent1_reg <= din;
            end
        end
    end

    assign full     = count_reg == 2'd2;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = ent0_reg;

endmodule
